// ===== design/hssd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hssd_pkg: shared types and constants of the surround stereo downmix
// Widths, register indexes, reset values, datapath operation codes and the
// Hilbert tap table used by the sequencer and the shared MAC.
// ----------------------------------------------------------------------------
package hssd_pkg;

    localparam int RING_DEPTH_DEF = 256;
    localparam int TAP_COUNT_DEF  = 100;

    localparam int SAMPLE_W   = 24;
    localparam int COEF_W     = 18;
    localparam int OPB_W      = 32;
    localparam int PROD_W     = COEF_W + OPB_W;
    localparam int ACC_W      = 72;
    localparam int CFG_IDX_W  = 3;
    localparam int TAP_IDX_W  = 7;
    localparam int IN_DATA_W  = 5 * SAMPLE_W;
    localparam int OUT_DATA_W = 3 * SAMPLE_W;
    localparam int WORD_W     = 2 * SAMPLE_W;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MASTER_GAIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRONT_W     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTRE_W    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SURR_WA     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SURR_WB     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LFE_EN      = 3'd5;

    localparam logic signed [COEF_W-1:0] RST_MASTER_GAIN = 18'sd25412;
    localparam logic signed [COEF_W-1:0] RST_FRONT_W     = 18'sd65536;
    localparam logic signed [COEF_W-1:0] RST_CENTRE_W    = 18'sd46341;
    localparam logic signed [COEF_W-1:0] RST_SURR_WA     = 18'sd57135;
    localparam logic signed [COEF_W-1:0] RST_SURR_WB     = 18'sd32106;

    // accumulate modes of the shared MAC
    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_SUB    = 2'd1;
    localparam logic [1:0] MODE_ADD_SH = 2'd2;

    localparam int SPLIT_SH = 24;

    typedef struct packed {
        logic                     vld;
        logic                     fir;
        logic                     side;
        logic                     keep;
        logic                     dst;
        logic [1:0]               mode;
        logic signed [COEF_W-1:0] a;
        logic signed [OPB_W-1:0]  b;
    } t_mac_op;

    localparam int HALF_TAPS_N = 50;
    localparam logic [TAP_IDX_W-1:0] TAP_MIRROR = 7'd99;
    localparam logic [TAP_IDX_W-1:0] TAP_HALF   = 7'd50;

    localparam logic signed [COEF_W-1:0] HALF_TAPS [HALF_TAPS_N] = '{
        18'sd106,   18'sd111,   18'sd118,   18'sd128,   18'sd142,
        18'sd158,   18'sd178,   18'sd201,   18'sd227,   18'sd258,
        18'sd293,   18'sd332,   18'sd375,   18'sd423,   18'sd476,
        18'sd535,   18'sd598,   18'sd668,   18'sd743,   18'sd825,
        18'sd915,   18'sd1011,  18'sd1115,  18'sd1228,  18'sd1351,
        18'sd1483,  18'sd1627,  18'sd1782,  18'sd1952,  18'sd2137,
        18'sd2339,  18'sd2560,  18'sd2804,  18'sd3075,  18'sd3376,
        18'sd3715,  18'sd4098,  18'sd4537,  18'sd5044,  18'sd5639,
        18'sd6350,  18'sd7216,  18'sd8300,  18'sd9701,  18'sd11592,
        18'sd14298, 18'sd18517, 18'sd26066, 18'sd43601, 18'sd131042
    };

    // antisymmetric tap set: second half is the negated mirror of the first
    function automatic logic signed [COEF_W-1:0] tap_at(input logic [TAP_IDX_W-1:0] idx);
        logic [TAP_IDX_W-1:0] mirror;
        mirror = TAP_MIRROR - idx;
        if (idx < TAP_HALF) begin
            return HALF_TAPS[idx[5:0]];
        end
        return -HALF_TAPS[mirror[5:0]];
    endfunction

endpackage

// ===== design/hilbert_surround_stereo_downmix.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hilbert_surround_stereo_downmix: matrix surround downmix to stereo
// Sequencer, surround delay ring, configuration registers and output register.
// ----------------------------------------------------------------------------
// One item is processed at a time; the next item is accepted only once the
// result of the last has been loaded into the output register. All products
// go through the single shared 18x32 multiplier: two filter products per tap,
// one per ring, eight weight products and four gain products, each group
// followed by a pipeline drain. Both surround rings share one RING_DEPTH x 48
// memory; ring entries not yet written count as zero through a fill counter,
// so no clearing pass follows reset. A finished result waits in the output
// register while the next item is taken and processed.
// ----------------------------------------------------------------------------
module hilbert_surround_stereo_downmix #(
    parameter int RING_DEPTH = hssd_pkg::RING_DEPTH_DEF,
    parameter int TAP_COUNT  = hssd_pkg::TAP_COUNT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [hssd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [hssd_pkg::COEF_W-1:0]         i_cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // front_left, front_right, centre, surround_left, surround_right
    input  logic [hssd_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // mix_left, mix_right, mix_lfe
    output logic [hssd_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic                                m_axis_tlast
);

    localparam int AW     = $clog2(RING_DEPTH);
    localparam int FILL_W = $clog2(RING_DEPTH + 1);
    localparam int TW     = $clog2(TAP_COUNT);
    localparam int SW     = hssd_pkg::SAMPLE_W;
    localparam int ACC_W  = hssd_pkg::ACC_W;

    localparam logic [AW-1:0]     DEPTH_M2  = AW'(RING_DEPTH - 2);
    localparam logic [AW-1:0]     IDX_LAST  = AW'(RING_DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(RING_DEPTH);
    localparam logic [TW-1:0]     TAP_LAST  = TW'(TAP_COUNT - 1);

    localparam logic signed [ACC_W-1:0] FIR_RND = ACC_W'(65536);
    localparam logic signed [ACC_W-1:0] OUT_RND = ACC_W'(64'sd2147483648);
    localparam logic signed [39:0]      SAT_MAX = 40'sd8388607;
    localparam logic signed [39:0]      SAT_MIN = -40'sd8388608;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_FIR    = 3'd1;
    localparam logic [2:0] S_FDRAIN = 3'd2;
    localparam logic [2:0] S_INNER  = 3'd3;
    localparam logic [2:0] S_IDRAIN = 3'd4;
    localparam logic [2:0] S_GAIN   = 3'd5;
    localparam logic [2:0] S_GDRAIN = 3'd6;

    // configuration
    logic signed [hssd_pkg::COEF_W-1:0] r_master_gain;
    logic signed [hssd_pkg::COEF_W-1:0] r_front_w;
    logic signed [hssd_pkg::COEF_W-1:0] r_centre_w;
    logic signed [hssd_pkg::COEF_W-1:0] r_surr_wa;
    logic signed [hssd_pkg::COEF_W-1:0] r_surr_wb;
    logic                               r_lfe_en;

    // sequencer
    logic [2:0]        r_state, n_state;
    logic [TW-1:0]     r_tap, n_tap;
    logic              r_side, n_side;
    logic [2:0]        r_step, n_step;
    logic [AW-1:0]     r_rp, n_rp;
    logic [AW-1:0]     r_wr_idx;
    logic [FILL_W-1:0] r_fill;

    // captured item and intermediate results
    logic signed [SW-1:0]              r_fl;
    logic signed [SW-1:0]              r_fr;
    logic signed [SW-1:0]              r_c;
    logic                              r_last;
    logic signed [hssd_pkg::OPB_W-1:0] r_hl;
    logic signed [hssd_pkg::OPB_W-1:0] r_hr;
    logic signed [hssd_pkg::OPB_W-1:0] r_hi_l;
    logic signed [hssd_pkg::OPB_W-1:0] r_hi_r;
    logic [SW-1:0]                     r_lo_l;
    logic [SW-1:0]                     r_lo_r;

    // ring memory
    logic [hssd_pkg::WORD_W-1:0] mem [RING_DEPTH];
    logic [hssd_pkg::WORD_W-1:0] r_rd_data;

    // output register
    logic                              r_m_valid;
    logic [hssd_pkg::OUT_DATA_W-1:0]   r_m_data;
    logic                              r_m_last;

    hssd_pkg::t_mac_op          w_op;
    logic                       w_clear;
    logic                       w_busy;
    logic                       w_accept;
    logic                       w_load_out;
    logic signed [ACC_W-1:0]    w_acc_l;
    logic signed [ACC_W-1:0]    w_acc_r;
    logic signed [ACC_W-1:0]    w_rnd_l;
    logic signed [ACC_W-1:0]    w_rnd_r;
    logic signed [ACC_W-1:0]    w_fin_l;
    logic signed [ACC_W-1:0]    w_fin_r;
    logic signed [SW:0]         w_lfe_sum;
    logic [SW-1:0]              w_mix_l;
    logic [SW-1:0]              w_mix_r;
    logic [SW-1:0]              w_lfe;

    function automatic logic [SW-1:0] sat24(input logic signed [39:0] v);
        if (v > SAT_MAX) begin
            return SW'(SAT_MAX);
        end
        if (v < SAT_MIN) begin
            return SW'(SAT_MIN);
        end
        return v[SW-1:0];
    endfunction

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_load_out    = (r_state == S_GDRAIN) && !w_busy && (!r_m_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_master_gain <= hssd_pkg::RST_MASTER_GAIN;
            r_front_w     <= hssd_pkg::RST_FRONT_W;
            r_centre_w    <= hssd_pkg::RST_CENTRE_W;
            r_surr_wa     <= hssd_pkg::RST_SURR_WA;
            r_surr_wb     <= hssd_pkg::RST_SURR_WB;
            r_lfe_en      <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                hssd_pkg::REG_MASTER_GAIN: r_master_gain <= i_cfg_data;
                hssd_pkg::REG_FRONT_W:     r_front_w     <= i_cfg_data;
                hssd_pkg::REG_CENTRE_W:    r_centre_w    <= i_cfg_data;
                hssd_pkg::REG_SURR_WA:     r_surr_wa     <= i_cfg_data;
                hssd_pkg::REG_SURR_WB:     r_surr_wb     <= i_cfg_data;
                hssd_pkg::REG_LFE_EN:      r_lfe_en      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // write the new surround pair at acceptance; reads start in the next cycle
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            mem[r_wr_idx] <= s_axis_tdata[5*SW-1:3*SW];
        end
        r_rd_data <= mem[r_rp];
    end

    always_comb begin
        n_state = r_state;
        n_tap   = r_tap;
        n_side  = r_side;
        n_step  = r_step;
        n_rp    = r_rp;
        w_clear = 1'b0;
        w_op    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_FIR;
                    n_tap   = '0;
                    n_side  = 1'b0;
                    n_rp    = r_wr_idx;
                    w_clear = 1'b1;
                end
            end
            S_FIR: begin
                w_op.vld  = 1'b1;
                w_op.fir  = 1'b1;
                w_op.side = r_side;
                w_op.dst  = r_side;
                w_op.keep = FILL_W'({r_tap, 1'b0}) < r_fill;
                w_op.mode = hssd_pkg::MODE_ADD;
                w_op.a    = hssd_pkg::tap_at(hssd_pkg::TAP_IDX_W'(r_tap));
                n_side    = !r_side;
                if (r_side) begin
                    n_rp  = (r_rp < AW'(2)) ? r_rp + DEPTH_M2 : r_rp - AW'(2);
                    n_tap = r_tap + TW'(1);
                    if (r_tap == TAP_LAST) begin
                        n_state = S_FDRAIN;
                    end
                end
            end
            S_FDRAIN: begin
                if (!w_busy) begin
                    n_state = S_INNER;
                    n_step  = '0;
                    w_clear = 1'b1;
                end
            end
            S_INNER: begin
                w_op.vld  = 1'b1;
                w_op.mode = hssd_pkg::MODE_ADD;
                w_op.dst  = r_step[2];
                case (r_step)
                    3'd0: begin w_op.a = r_front_w;  w_op.b = hssd_pkg::OPB_W'(r_fl); end
                    3'd1: begin w_op.a = r_centre_w; w_op.b = hssd_pkg::OPB_W'(r_c);  end
                    3'd2: begin w_op.a = r_surr_wa;  w_op.b = r_hl; end
                    3'd3: begin w_op.a = r_surr_wb;  w_op.b = r_hr; end
                    3'd4: begin w_op.a = r_front_w;  w_op.b = hssd_pkg::OPB_W'(r_fr); end
                    3'd5: begin w_op.a = r_centre_w; w_op.b = hssd_pkg::OPB_W'(r_c);  end
                    3'd6: begin w_op.a = r_surr_wb;  w_op.b = r_hl; end
                    default: begin
                        w_op.a    = r_surr_wa;
                        w_op.b    = r_hr;
                        w_op.mode = hssd_pkg::MODE_SUB;
                    end
                endcase
                n_step = r_step + 3'd1;
                if (r_step == 3'd7) begin
                    n_state = S_IDRAIN;
                end
            end
            S_IDRAIN: begin
                if (!w_busy) begin
                    n_state = S_GAIN;
                    n_step  = '0;
                    w_clear = 1'b1;
                end
            end
            S_GAIN: begin
                // gain times inner value, split into a high and a low part
                w_op.vld = 1'b1;
                w_op.a   = r_master_gain;
                w_op.dst = r_step[1];
                case (r_step[1:0])
                    2'd0: begin w_op.b = r_hi_l; w_op.mode = hssd_pkg::MODE_ADD_SH; end
                    2'd1: begin
                        w_op.b    = hssd_pkg::OPB_W'({1'b0, r_lo_l});
                        w_op.mode = hssd_pkg::MODE_ADD;
                    end
                    2'd2: begin w_op.b = r_hi_r; w_op.mode = hssd_pkg::MODE_ADD_SH; end
                    default: begin
                        w_op.b    = hssd_pkg::OPB_W'({1'b0, r_lo_r});
                        w_op.mode = hssd_pkg::MODE_ADD;
                    end
                endcase
                n_step = r_step + 3'd1;
                if (r_step == 3'd3) begin
                    n_state = S_GDRAIN;
                end
            end
            S_GDRAIN: begin
                if (w_load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_tap    <= '0;
            r_side   <= 1'b0;
            r_step   <= '0;
            r_rp     <= '0;
            r_wr_idx <= '0;
            r_fill   <= '0;
        end else begin
            r_state <= n_state;
            r_tap   <= n_tap;
            r_side  <= n_side;
            r_step  <= n_step;
            r_rp    <= n_rp;
            if (w_accept) begin
                r_wr_idx <= (r_wr_idx == IDX_LAST) ? '0 : r_wr_idx + AW'(1);
                if (r_fill != FILL_FULL) begin
                    r_fill <= r_fill + FILL_W'(1);
                end
            end
        end
    end

    assign w_rnd_l = w_acc_l + FIR_RND;
    assign w_rnd_r = w_acc_r + FIR_RND;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_fl   <= s_axis_tdata[SW-1:0];
            r_fr   <= s_axis_tdata[2*SW-1:SW];
            r_c    <= s_axis_tdata[3*SW-1:2*SW];
            r_last <= s_axis_tlast;
        end
        if (r_state == S_FDRAIN && !w_busy) begin
            r_hl <= w_rnd_l[17 +: hssd_pkg::OPB_W];
            r_hr <= w_rnd_r[17 +: hssd_pkg::OPB_W];
        end
        if (r_state == S_IDRAIN && !w_busy) begin
            r_hi_l <= w_acc_l[hssd_pkg::SPLIT_SH +: hssd_pkg::OPB_W];
            r_hi_r <= w_acc_r[hssd_pkg::SPLIT_SH +: hssd_pkg::OPB_W];
            r_lo_l <= w_acc_l[SW-1:0];
            r_lo_r <= w_acc_r[SW-1:0];
        end
    end

    always_comb begin
        w_fin_l   = w_acc_l + OUT_RND;
        w_fin_r   = w_acc_r + OUT_RND;
        w_mix_l   = sat24(w_fin_l[ACC_W-1:32]);
        w_mix_r   = sat24(w_fin_r[ACC_W-1:32]);
        w_lfe_sum = (SW+1)'(r_fl) + (SW+1)'(r_fr) + 25'sd1;
        w_lfe     = r_lfe_en ? w_lfe_sum[SW:1] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_load_out) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
        if (w_load_out) begin
            r_m_data <= {w_lfe, w_mix_r, w_mix_l};
            r_m_last <= r_last;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tlast  = r_m_last;

    hssd_mac u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_op      (w_op),
        .i_clear   (w_clear),
        .i_rd_data (r_rd_data),
        .o_acc_l   (w_acc_l),
        .o_acc_r   (w_acc_r),
        .o_busy    (w_busy)
    );

    a_accept_starts_fir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == S_FIR)
        else $error("accepted item did not start the filter pass");

    a_clear_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_clear && (r_state == S_FDRAIN || r_state == S_IDRAIN)) |-> !w_busy)
        else $error("accumulators cleared with products in flight");

    a_result_from_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state) == S_GDRAIN)
        else $error("result loaded outside the final drain");

    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_FULL)
        else $error("fill count beyond ring depth");

endmodule

// ===== design/hssd_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hssd_mac: shared multiply-accumulate unit
// Two-stage unit: operand select and multiply, then add into one of two
// accumulators. Filter operations take their sample from the ring read data.
// ----------------------------------------------------------------------------
module hssd_mac (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  hssd_pkg::t_mac_op                     i_op,
    input  logic                                  i_clear,
    input  logic [hssd_pkg::WORD_W-1:0]           i_rd_data,
    output logic signed [hssd_pkg::ACC_W-1:0]     o_acc_l,
    output logic signed [hssd_pkg::ACC_W-1:0]     o_acc_r,
    output logic                                  o_busy
);

    hssd_pkg::t_mac_op                      r_s1;
    logic                                   r_s2_vld;
    logic                                   r_s2_dst;
    logic [1:0]                             r_s2_mode;
    logic signed [hssd_pkg::PROD_W-1:0]     r_s2_prod;
    logic signed [hssd_pkg::ACC_W-1:0]      r_acc_l;
    logic signed [hssd_pkg::ACC_W-1:0]      r_acc_r;

    logic signed [hssd_pkg::SAMPLE_W-1:0]   w_smp;
    logic signed [hssd_pkg::OPB_W-1:0]      w_b;
    logic signed [hssd_pkg::PROD_W-1:0]     n_prod;
    logic signed [hssd_pkg::ACC_W-1:0]      w_term;
    logic signed [hssd_pkg::ACC_W-1:0]      w_base;
    logic signed [hssd_pkg::ACC_W-1:0]      n_sum;

    always_comb begin
        w_smp = r_s1.side ? i_rd_data[hssd_pkg::WORD_W-1:hssd_pkg::SAMPLE_W]
                          : i_rd_data[hssd_pkg::SAMPLE_W-1:0];
        if (r_s1.fir) begin
            w_b = r_s1.keep ? hssd_pkg::OPB_W'(w_smp) : '0;
        end else begin
            w_b = r_s1.b;
        end
        n_prod = r_s1.a * w_b;
    end

    always_comb begin
        w_base = r_s2_dst ? r_acc_r : r_acc_l;
        w_term = hssd_pkg::ACC_W'(r_s2_prod);
        case (r_s2_mode)
            hssd_pkg::MODE_SUB:    n_sum = w_base - w_term;
            hssd_pkg::MODE_ADD_SH: n_sum = w_base + (w_term <<< hssd_pkg::SPLIT_SH);
            default:               n_sum = w_base + w_term;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1     <= '0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1     <= i_op;
            r_s2_vld <= r_s1.vld;
        end
        r_s2_dst  <= r_s1.dst;
        r_s2_mode <= r_s1.mode;
        r_s2_prod <= n_prod;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_acc_l <= '0;
            r_acc_r <= '0;
        end else if (r_s2_vld) begin
            if (r_s2_dst) begin
                r_acc_r <= n_sum;
            end else begin
                r_acc_l <= n_sum;
            end
        end
    end

    assign o_acc_l = r_acc_l;
    assign o_acc_r = r_acc_r;
    assign o_busy  = r_s1.vld | r_s2_vld;

endmodule
